/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the envelope RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/asrenv_pkg.sv */
// Package for the cosine-eased attack/sustain/release envelope.
// Holds widths, codes, the queue item type and the easing table; no dependencies.
package asrenv_pkg;

    // Field widths
    localparam int unsigned LEVEL_W    = 16;
    localparam int unsigned RATE_W     = 16;
    localparam int unsigned TIME_W     = 24;
    localparam int unsigned DT_W       = 16;
    localparam int unsigned EASE_W     = 17;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    // Easing table size (power of two)
    localparam int unsigned COS_TABLE_ENTRIES = 256;
    localparam int unsigned COS_IDX_W         = $clog2(COS_TABLE_ENTRIES);

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [LEVEL_W-1:0] TARGET_LEVEL_RST = 16'd65535;
    localparam logic [RATE_W-1:0]  RISE_RATE_RST    = 16'd256;
    localparam logic [TIME_W-1:0]  SUSTAIN_TIME_RST = 24'd65536;
    localparam logic [RATE_W-1:0]  FALL_RATE_RST    = 16'd256;

    // Fixed-point constants for the table build
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_LEVEL = 2'd0,
        CFG_RISE_RATE    = 2'd1,
        CFG_SUSTAIN_TIME = 2'd2,
        CFG_FALL_RATE    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_RISE    = 2'd0,
        PH_SUSTAIN = 2'd1,
        PH_RELEASE = 2'd2
    } phase_t;

    // One updated envelope state, front to back
    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               done;
        phase_t             phase;
    } env_item_t;

    typedef logic [EASE_W-1:0] ease_tab_t [COS_TABLE_ENTRIES + 1];

    // (1 - cos(pi*i/N))/2 in Q0.16 for the lower half, Q30 Taylor series
    function automatic logic [EASE_W-1:0] ease_low_half(input logic [63:0] i);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        longint      c;
        t    = (PI_Q30 * i) / COS_TABLE_ENTRIES;
        t2   = (t * t) >> 30;
        term = ONE_Q30;
        c    = longint'(ONE_Q30);
        for (int k = 1; k <= 10; k++)
        begin
            term = (term * t2) >> 30;
            case (k)
                1:       term = term / 2;
                2:       term = term / 12;
                3:       term = term / 30;
                4:       term = term / 56;
                5:       term = term / 90;
                6:       term = term / 132;
                7:       term = term / 182;
                8:       term = term / 240;
                9:       term = term / 306;
                default: term = term / 380;
            endcase
            if (k % 2 == 1)
            begin
                c = c - longint'(term);
            end
            else
            begin
                c = c + longint'(term);
            end
        end
        if (c < 0)
        begin
            c = 0;
        end
        if (c > longint'(ONE_Q30))
        begin
            c = longint'(ONE_Q30);
        end
        return EASE_W'((ONE_Q30 - 64'(c) + 64'd16384) >> 15);
    endfunction

    // Full table, upper half mirrored from the lower
    function automatic ease_tab_t build_ease_tab();
        ease_tab_t tab;
        for (int unsigned i = 0; i <= COS_TABLE_ENTRIES; i++)
        begin
            if (2 * i <= COS_TABLE_ENTRIES)
            begin
                tab[i] = ease_low_half(64'(i));
            end
            else
            begin
                tab[i] = EASE_W'(65536) - ease_low_half(64'(COS_TABLE_ENTRIES - i));
            end
        end
        return tab;
    endfunction

    localparam ease_tab_t EASE_TAB = build_ease_tab();

endpackage

/* hw/rtl/asr_envelope_cosine_eased.sv */
// Top level of the cosine-eased attack/sustain/release envelope generator.
// Uses asrenv_pkg, asrenv_front, asrenv_queue and asrenv_ease.
//
//   Channel  Handshake            Payload
//   -------  -------------------  ---------------------------------
//   config   cfg_we               cfg_index, cfg_data
//   tick in  in_valid / in_ready  delta_time
//   result   out_valid/out_ready  eased_level, done_res, phase
//
// One tick per cycle sustained while the queue has room; the front's
// combinational multiply, add and compare on the level sets that figure.
// A result passes from the queue write on the edge that takes its tick
// through the table stage, then interpolation into the output register.
// Asynchronous reset, no clearing pass; state and config regs return to defaults.
// With out_ready low the four-entry queue fills, then in_ready drops.

module asr_envelope_cosine_eased
    import asrenv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DT_W-1:0]       delta_time,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LEVEL_W-1:0]    eased_level,
    output logic                  done_res,
    output logic [1:0]            phase
);

    logic      queue_full;
    logic      queue_empty;
    logic      push_valid;
    logic      pop;
    env_item_t push_item;
    env_item_t pop_item;
    phase_t    out_phase;

    // Request intake and envelope state
    asrenv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .delta_time (delta_time),
        .queue_full (queue_full),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    // Decoupling queue
    asrenv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .pop_item   (pop_item),
        .empty      (queue_empty)
    );

    // Easing and result delivery
    asrenv_ease u_ease (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (queue_empty),
        .pop_item    (pop_item),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .eased_level (eased_level),
        .done_res    (done_res),
        .phase       (out_phase)
    );

    assign phase = out_phase;

endmodule

/* hw/rtl/asrenv_front.sv */
// Front end of the envelope: configuration registers, request intake and
// the phase/level/hold-timer update. Uses asrenv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module asrenv_front
    import asrenv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DT_W-1:0]       delta_time,
    input  logic                  queue_full,
    output logic                  push_valid,
    output env_item_t             push_item
);

    logic [LEVEL_W-1:0] target_level_reg;
    logic [RATE_W-1:0]  rise_rate_reg;
    logic [TIME_W-1:0]  sustain_time_reg;
    logic [RATE_W-1:0]  fall_rate_reg;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [TIME_W-1:0]  hold_timer_reg;
    logic [TIME_W-1:0]  hold_timer_next;
    logic               finished_reg;
    logic               finished_next;

    logic [DT_W+RATE_W-1:0] rise_prod;
    logic [DT_W+RATE_W-1:0] fall_prod;
    logic [TIME_W-1:0]      rise_step;
    logic [TIME_W-1:0]      fall_step;
    logic [TIME_W:0]        rise_sum;
    logic                   rise_over;
    logic                   fall_end;
    logic                   hold_end;
    logic                   accept;

    // Intake: only the queue can hold us off
    assign in_ready   = !queue_full;
    assign accept     = in_valid && in_ready;
    assign push_valid = accept;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_level_reg <= TARGET_LEVEL_RST;
            rise_rate_reg    <= RISE_RATE_RST;
            sustain_time_reg <= SUSTAIN_TIME_RST;
            fall_rate_reg    <= FALL_RATE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TARGET_LEVEL: target_level_reg <= cfg_data[LEVEL_W-1:0];
                CFG_RISE_RATE:    rise_rate_reg    <= cfg_data[RATE_W-1:0];
                CFG_SUSTAIN_TIME: sustain_time_reg <= cfg_data[TIME_W-1:0];
                CFG_FALL_RATE:    fall_rate_reg    <= cfg_data[RATE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Step sizes: Q0.16 s times Q8.8 per s, truncated to Q8.16
    assign rise_prod = delta_time * rise_rate_reg;
    assign fall_prod = delta_time * fall_rate_reg;
    assign rise_step = rise_prod[DT_W+RATE_W-1:8];
    assign fall_step = fall_prod[DT_W+RATE_W-1:8];
    assign rise_sum  = {(TIME_W + 1 - LEVEL_W)'(0), level_reg} + {1'b0, rise_step};
    assign rise_over = rise_sum > {(TIME_W + 1 - LEVEL_W)'(0), target_level_reg};
    assign fall_end  = fall_step >= {(TIME_W - LEVEL_W)'(0), level_reg};
    assign hold_end  = {(TIME_W - DT_W)'(0), delta_time} >= hold_timer_reg;

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        level_next      = level_reg;
        hold_timer_next = hold_timer_reg;
        finished_next   = finished_reg;
        if (!finished_reg)
        begin
            case (phase_reg)
                PH_RISE:
                begin
                    if (rise_over)
                    begin
                        level_next      = target_level_reg;
                        phase_next      = PH_SUSTAIN;
                        hold_timer_next = sustain_time_reg;
                    end
                    else
                    begin
                        level_next = rise_sum[LEVEL_W-1:0];
                    end
                end
                PH_SUSTAIN:
                begin
                    if (hold_end)
                    begin
                        hold_timer_next = '0;
                        phase_next      = PH_RELEASE;
                    end
                    else
                    begin
                        hold_timer_next = hold_timer_reg - {(TIME_W - DT_W)'(0), delta_time};
                    end
                end
                default:
                begin
                    // release
                    if (fall_end)
                    begin
                        level_next    = '0;
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        level_next = level_reg - fall_step[LEVEL_W-1:0];
                    end
                end
            endcase
        end
    end

    // Result of this request, as seen after the update
    always_comb
    begin
        push_item.level = level_next;
        push_item.done  = finished_next;
        push_item.phase = phase_next;
    end

    // Envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RISE;
            level_reg      <= '0;
            hold_timer_reg <= SUSTAIN_TIME_RST;
            finished_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            level_reg      <= level_next;
            hold_timer_reg <= hold_timer_next;
            finished_reg   <= finished_next;
        end
    end

    // A finished envelope sits at zero in release, and stays finished
    `ASSERT_IMPL(a_finished_at_zero, finished_reg,
                 (level_reg == '0) && (phase_reg == PH_RELEASE),
                 "finished envelope not at zero in release")
    `ASSERT_NEXT(a_finished_sticky, finished_reg, finished_reg,
                 "finished flag cleared")

endmodule

/* hw/rtl/asrenv_queue.sv */
// Short register queue between the envelope front and the easing back end.
// Uses asrenv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module asrenv_queue
    import asrenv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  env_item_t push_item,
    output logic      full,
    input  logic      pop,
    output env_item_t pop_item,
    output logic      empty
);

    env_item_t              store_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_pop;

    assign full     = count_reg == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_pop   = pop && !empty;
    assign pop_item = store_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
            end
            if (push_valid && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push_valid && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `ASSERT_IMPL(a_no_overflow, push_valid, !full, "push into a full queue")
    `ASSERT_NEXT(a_pop_drains, do_pop && !push_valid,
                 count_reg == ($past(count_reg) - 1'b1), "pop did not drain the queue")

endmodule

/* hw/rtl/asrenv_ease.sv */
// Back end: cosine easing by table lookup and linear interpolation, a table
// stage then an interpolation stage that ends in the output register.
// Uses asrenv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module asrenv_ease
    import asrenv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  env_item_t          pop_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEVEL_W-1:0] eased_level,
    output logic               done_res,
    output phase_t             phase
);

    logic                   advance;
    logic [COS_IDX_W-1:0]   tab_idx;
    logic [COS_IDX_W:0]     tab_idx_lo;
    logic [COS_IDX_W:0]     tab_idx_hi;
    logic [EASE_W-1:0]      tab_lo;
    logic [EASE_W-1:0]      tab_hi;
    logic [LEVEL_W-1:0]     frac;

    logic                   a_valid_reg;
    logic [EASE_W-1:0]      a_lo_reg;
    logic [EASE_W-1:0]      a_diff_reg;
    logic                   a_up_reg;
    logic [LEVEL_W-1:0]     a_frac_reg;
    logic                   a_done_reg;
    phase_t                 a_phase_reg;

    logic [EASE_W+LEVEL_W-1:0] prod;
    logic [EASE_W-1:0]         adj;
    logic [EASE_W:0]           interp;
    logic [LEVEL_W-1:0]        eased_sat;

    logic                   out_valid_reg;
    logic [LEVEL_W-1:0]     eased_reg;
    logic                   done_reg;
    phase_t                 phase_reg;

    // Whole back end moves together when the output slot frees up
    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && !empty;

    // Table address: pos = level * N, index is the top bits, fraction the rest
    assign tab_idx    = pop_item.level[LEVEL_W-1 -: COS_IDX_W];
    assign tab_idx_lo = {1'b0, tab_idx};
    assign tab_idx_hi = {1'b0, tab_idx} + 1'b1;
    assign frac       = LEVEL_W'({pop_item.level, COS_IDX_W'(0)});
    assign tab_lo     = EASE_TAB[tab_idx_lo];
    assign tab_hi     = EASE_TAB[tab_idx_hi];

    // Stage A: table read and neighbour difference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_lo_reg    <= tab_lo;
            a_up_reg    <= tab_hi >= tab_lo;
            a_diff_reg  <= (tab_hi >= tab_lo) ? tab_hi - tab_lo : tab_lo - tab_hi;
            a_frac_reg  <= frac;
            a_done_reg  <= pop_item.done;
            a_phase_reg <= pop_item.phase;
        end
    end

    // Stage B: truncated interpolation, saturate at full scale
    assign prod   = a_diff_reg * a_frac_reg;
    assign adj    = prod[EASE_W+LEVEL_W-1:LEVEL_W];
    assign interp = a_up_reg ? {1'b0, a_lo_reg} + {1'b0, adj}
                             : {1'b0, a_lo_reg} - {1'b0, adj};
    assign eased_sat = (interp > (EASE_W + 1)'(16'hFFFF)) ? 16'hFFFF : interp[LEVEL_W-1:0];

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            eased_reg <= eased_sat;
            done_reg  <= a_done_reg;
            phase_reg <= a_phase_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign eased_level = eased_reg;
    assign done_res    = done_reg;
    assign phase       = phase_reg;

    // A finished envelope has level zero, whose eased value is zero
    `ASSERT_IMPL(a_done_eased_zero, out_valid_reg && done_reg, eased_reg == '0,
                 "finished result with non-zero eased level")

endmodule
